### sv/whp_pkg.sv
package whp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] sample_rate;
        logic [7:0]  bits_per_sample;
        logic [7:0]  channels;
        logic [31:0] data_len;
    } t_out;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_FMT,
        PH_SKIP,
        PH_CHUNK,
        PH_DONE
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [5:0]  byte_index;
        logic [31:0] shift_word;
        logic [31:0] skip_left;
        logic        tag_match;
        logic [31:0] rate_hold;
        logic [7:0]  bits_hold;
        logic [7:0]  chan_hold;
        logic        result_given;
    } t_state;

    localparam logic [2:0] ST_DATA_FOUND = 3'd0;
    localparam logic [2:0] ST_NO_DATA    = 3'd1;
    localparam logic [2:0] ST_TRUNCATED  = 3'd2;
    localparam logic [2:0] ST_BAD_RIFF   = 3'd3;
    localparam logic [2:0] ST_BAD_WAVE   = 3'd4;
    localparam logic [2:0] ST_BAD_FMT    = 3'd5;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_BASE = 32'd16;
    localparam logic [31:0] SKIP_MAX = 32'h7FFF_FFFF;

    localparam logic [5:0] IDX_TAG_END   = 6'd3;
    localparam logic [5:0] IDX_SIZE_END  = 6'd7;
    localparam logic [5:0] IDX_CHAN      = 6'd10;
    localparam logic [5:0] IDX_HDR_END   = 6'd11;
    localparam logic [5:0] IDX_RATE_END  = 6'd15;
    localparam logic [5:0] IDX_BITS      = 6'd22;
    localparam logic [5:0] IDX_FMT_END   = 6'd23;
    localparam logic [5:0] IDX_CHUNK_END = 6'd7;

    function automatic t_state reset_state();
        t_state s;
        s.phase        = PH_RIFF;
        s.byte_index   = '0;
        s.shift_word   = '0;
        s.skip_left    = '0;
        s.tag_match    = 1'b1;
        s.rate_hold    = '0;
        s.bits_hold    = '0;
        s.chan_hold    = '0;
        s.result_given = 1'b0;
        return s;
    endfunction

endpackage

### sv/wav_header_parser_top.sv
// Streaming RIFF/WAVE header parser. Feed the file one byte per transaction,
// with is_last set on its final byte; one result transaction is given per
// file (status, sample rate, bits per sample, channel count, data length).
// A byte is taken every clock cycle while the input stage is not stalled: it
// is held in an input register, the parse state advances by one step of
// combinational logic, and a result lands in the output register. While
// the output register holds a result that is stalled, the input stage holds one
// byte and then stalls. Bytes after a result are ignored up to the end mark;
// the next byte starts a new file.
module wav_header_parser_top import whp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic   r_in_valid;
    t_in    r_in_data;
    t_state r_state;
    logic   r_out_valid;
    t_out   r_out_data;

    t_state n_state;
    logic   n_out_valid;
    logic   step_emit;
    t_out   step_result;
    logic   advance;

    whp_step u_step (
        .i_state  (r_state),
        .i_in     (r_in_data),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    assign advance     = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign n_out_valid = (r_out_valid && i_out_stall) || (advance && step_emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= reset_state();
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_data <= i_in_data;
        end
        if (advance && step_emit) begin
            r_out_data <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= ST_BAD_FMT))
        else $error("result status out of range");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_DATA_FOUND
            && o_out_data.status != ST_NO_DATA)
        |-> (o_out_data.sample_rate == '0 && o_out_data.data_len == '0
            && o_out_data.channels == '0 && o_out_data.bits_per_sample == '0))
        else $error("error result carries non-zero fields");

    a_no_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_NO_DATA) |-> (o_out_data.data_len == '0))
        else $error("no-data result carries a length");

    a_done_given: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.result_given == (r_state.phase == PH_DONE))
        else $error("result flag and done phase disagree");

endmodule

### sv/whp_step.sv
module whp_step import whp_pkg::*; (
    input  t_state i_state,
    input  t_in    i_in,
    output t_state o_state,
    output logic   o_emit,
    output t_out   o_result
);

    t_state s;
    logic   emit;
    t_out   res;
    logic   skip_ok;

    always_comb begin
        s       = i_state;
        emit    = 1'b0;
        res     = '0;
        skip_ok = 1'b0;

        if (s.phase != PH_DONE && s.phase != PH_SKIP) begin
            s.shift_word = {i_in.data_byte, s.shift_word[31:8]};
        end

        case (s.phase)
            PH_RIFF: begin
                if (s.byte_index == IDX_TAG_END) begin
                    s.tag_match = (s.shift_word == TAG_RIFF);
                end
                if (s.byte_index >= IDX_HDR_END) begin
                    if (!s.tag_match) begin
                        emit       = 1'b1;
                        res.status = ST_BAD_RIFF;
                    end else if (s.shift_word != TAG_WAVE) begin
                        emit       = 1'b1;
                        res.status = ST_BAD_WAVE;
                    end else begin
                        s.phase      = PH_FMT;
                        s.byte_index = '0;
                        s.tag_match  = 1'b1;
                    end
                end else begin
                    s.byte_index = s.byte_index + 6'd1;
                end
            end
            PH_FMT: begin
                if (s.byte_index == IDX_TAG_END) begin
                    s.tag_match = (s.shift_word == TAG_FMT);
                end else if (s.byte_index == IDX_SIZE_END) begin
                    s.skip_left = s.shift_word;
                end else if (s.byte_index == IDX_CHAN) begin
                    s.chan_hold = i_in.data_byte;
                end else if (s.byte_index == IDX_RATE_END) begin
                    s.rate_hold = s.shift_word;
                end else if (s.byte_index == IDX_BITS) begin
                    s.bits_hold = i_in.data_byte;
                end
                if (s.byte_index >= IDX_FMT_END) begin
                    if (!s.tag_match) begin
                        emit       = 1'b1;
                        res.status = ST_BAD_FMT;
                    end else begin
                        s.byte_index = '0;
                        s.tag_match  = 1'b1;
                        skip_ok = (s.skip_left > FMT_BASE) && (s.skip_left <= SKIP_MAX);
                        if (skip_ok) begin
                            s.skip_left = s.skip_left - FMT_BASE;
                            s.phase     = PH_SKIP;
                        end else begin
                            s.skip_left = '0;
                            s.phase     = PH_CHUNK;
                        end
                    end
                end else begin
                    s.byte_index = s.byte_index + 6'd1;
                end
            end
            PH_SKIP: begin
                s.skip_left = s.skip_left - 32'd1;
                if (s.skip_left == '0) begin
                    s.phase      = PH_CHUNK;
                    s.byte_index = '0;
                end
            end
            PH_CHUNK: begin
                if (s.byte_index == IDX_TAG_END) begin
                    s.tag_match = (s.shift_word == TAG_DATA);
                end
                if (s.byte_index >= IDX_CHUNK_END) begin
                    s.byte_index = '0;
                    if (s.tag_match) begin
                        emit                = 1'b1;
                        res.status          = ST_DATA_FOUND;
                        res.sample_rate     = s.rate_hold;
                        res.bits_per_sample = s.bits_hold;
                        res.channels        = s.chan_hold;
                        res.data_len        = s.shift_word;
                    end else begin
                        s.tag_match = 1'b1;
                        s.skip_left = s.shift_word;
                        if (s.shift_word != '0) begin
                            s.phase = PH_SKIP;
                        end
                    end
                end else begin
                    s.byte_index = s.byte_index + 6'd1;
                end
            end
            default: begin
            end
        endcase

        if (emit) begin
            s.phase        = PH_DONE;
            s.result_given = 1'b1;
        end

        if (i_in.is_last) begin
            if (!emit && !s.result_given) begin
                emit = 1'b1;
                if (s.phase == PH_RIFF || s.phase == PH_FMT) begin
                    res.status = ST_TRUNCATED;
                end else begin
                    res.status          = ST_NO_DATA;
                    res.sample_rate     = s.rate_hold;
                    res.bits_per_sample = s.bits_hold;
                    res.channels        = s.chan_hold;
                    res.data_len        = '0;
                end
            end
            s = reset_state();
        end
    end

    assign o_state  = s;
    assign o_emit   = emit;
    assign o_result = res;

endmodule
